@@ rtl/tbp_pkg.sv @@
package tbp_pkg;

   // table geometry
   localparam int PHT_INDEX_BITS = 12;
   localparam int BHT_INDEX_BITS = 8;
   localparam int HISTORY_BITS   = 4;
   localparam int ADDR_BITS      = 32;

   // clearing sweep covers the deeper of the two tables
   localparam int CLEAR_BITS = (PHT_INDEX_BITS > BHT_INDEX_BITS) ? PHT_INDEX_BITS
                                                                 : BHT_INDEX_BITS;
   // address bits above bit 1 placed over the history before trimming
   localparam int WIDE_BITS  = PHT_INDEX_BITS + HISTORY_BITS;

   typedef logic [ADDR_BITS-1:0]      addr_type;
   typedef logic [BHT_INDEX_BITS-1:0] bht_idx_type;
   typedef logic [PHT_INDEX_BITS-1:0] pht_idx_type;
   typedef logic [HISTORY_BITS-1:0]   hist_type;
   typedef logic [CLEAR_BITS-1:0]     clear_idx_type;
   typedef logic [WIDE_BITS-1:0]      wide_idx_type;
   typedef logic [1:0]                counter_type;

   // 2-bit saturating counter codes
   localparam counter_type CNT_STRONG_NT = 2'd0;
   localparam counter_type CNT_WEAK_NT   = 2'd1;
   localparam counter_type CNT_WEAK_T    = 2'd2;
   localparam counter_type CNT_STRONG_T  = 2'd3;

   // reset sweep command to both tables
   typedef struct packed {
      logic          active;
      clear_idx_type index;
   } clear_type;

   // per-stage pipeline control
   typedef struct packed {
      logic load;
      logic advance;
   } stage_ctl_type;

   // history stage to pattern stage
   typedef struct packed {
      logic        valid;
      pht_idx_type pht_idx;
      logic        taken;
   } pht_req_type;

   // pattern stage result
   typedef struct packed {
      logic valid;
      logic predicted;
   } pred_type;

   function automatic bht_idx_type history_index(addr_type addr);
      return addr[BHT_INDEX_BITS+1:2];
   endfunction

   // address bits over the history, low bits kept
   function automatic pht_idx_type pattern_index(addr_type addr, hist_type hist);
      wide_idx_type wide;
      wide = (WIDE_BITS'(addr[ADDR_BITS-1:2]) << HISTORY_BITS) | WIDE_BITS'(hist);
      return wide[PHT_INDEX_BITS-1:0];
   endfunction

   function automatic hist_type shift_history(hist_type hist, logic taken);
      return HISTORY_BITS'({hist, taken});
   endfunction

   function automatic counter_type next_counter(counter_type cnt, logic taken);
      counter_type result;
      if (taken) begin
         result = (cnt == CNT_STRONG_T) ? CNT_STRONG_T : cnt + 2'd1;
      end else begin
         result = (cnt == CNT_STRONG_NT) ? CNT_STRONG_NT : cnt - 2'd1;
      end
      return result;
   endfunction

endpackage

@@ rtl/tbp_req_if.sv @@
interface tbp_req_if;
   import tbp_pkg::*;

   logic     valid;
   logic     ready;
   addr_type branch_address;
   logic     taken;

   modport source (output valid, output branch_address, output taken, input ready);
   modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

@@ rtl/tbp_rsp_if.sv @@
interface tbp_rsp_if;
   logic valid;
   logic ready;
   logic predicted_taken;

   modport source (output valid, output predicted_taken, input ready);
   modport sink   (input valid, input predicted_taken, output ready);
endinterface

@@ rtl/tbp_hist_stage.sv @@
module tbp_hist_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  tbp_pkg::clear_type     clr,
   input  tbp_pkg::stage_ctl_type ctl,
   input  tbp_pkg::addr_type      in_addr,
   input  logic                  in_taken,
   output tbp_pkg::pht_req_type   pht_req
);
   import tbp_pkg::*;

   localparam int BHT_DEPTH = 1 << BHT_INDEX_BITS;

   hist_type    bht_mem_ff [BHT_DEPTH];
   hist_type    bht_rd_ff;
   logic        s1_valid_ff, s1_valid_in;
   addr_type    s1_addr_ff;
   bht_idx_type s1_bidx_ff;
   logic        s1_taken_ff;
   logic        fwd_valid_ff;
   bht_idx_type fwd_idx_ff;
   hist_type    fwd_hist_ff;
   hist_type    hist;
   hist_type    hist_next;

   // history with the last write forwarded over the memory read
   always_comb begin
      hist      = (fwd_valid_ff && (fwd_idx_ff == s1_bidx_ff)) ? fwd_hist_ff : bht_rd_ff;
      hist_next = shift_history(hist, s1_taken_ff);
   end

   assign pht_req.valid   = s1_valid_ff;
   assign pht_req.pht_idx = pattern_index(s1_addr_ff, hist);
   assign pht_req.taken   = s1_taken_ff;

   // stage occupancy
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (ctl.load) begin
         s1_valid_in = 1'b1;
      end else if (ctl.advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (ctl.advance) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   // item payload and last history write
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         s1_addr_ff  <= in_addr;
         s1_bidx_ff  <= history_index(in_addr);
         s1_taken_ff <= in_taken;
      end
      if (ctl.advance) begin
         fwd_idx_ff  <= s1_bidx_ff;
         fwd_hist_ff <= hist_next;
      end
   end

   // history table: read on accept, write back as the item moves on
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         bht_rd_ff <= bht_mem_ff[history_index(in_addr)];
      end
      if (clr.active) begin
         bht_mem_ff[clr.index[BHT_INDEX_BITS-1:0]] <= '0;
      end else if (ctl.advance) begin
         bht_mem_ff[s1_bidx_ff] <= hist_next;
      end
   end

endmodule

@@ rtl/tbp_pattern_stage.sv @@
module tbp_pattern_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  tbp_pkg::clear_type     clr,
   input  tbp_pkg::stage_ctl_type ctl,
   input  tbp_pkg::pht_req_type   pht_req,
   output tbp_pkg::pred_type      pred
);
   import tbp_pkg::*;

   localparam int PHT_DEPTH = 1 << PHT_INDEX_BITS;

   counter_type pht_mem_ff [PHT_DEPTH];
   counter_type pht_rd_ff;
   logic        s2_valid_ff, s2_valid_in;
   pht_idx_type s2_idx_ff;
   logic        s2_taken_ff;
   logic        fwd_valid_ff;
   pht_idx_type fwd_idx_ff;
   counter_type fwd_cnt_ff;
   counter_type cnt;
   counter_type cnt_next;

   // counter with the last write forwarded over the memory read
   always_comb begin
      cnt      = (fwd_valid_ff && (fwd_idx_ff == s2_idx_ff)) ? fwd_cnt_ff : pht_rd_ff;
      cnt_next = next_counter(cnt, s2_taken_ff);
   end

   assign pred.valid     = s2_valid_ff;
   assign pred.predicted = (cnt >= CNT_WEAK_T);

   // stage occupancy
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (ctl.load) begin
         s2_valid_in = 1'b1;
      end else if (ctl.advance) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (ctl.advance) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   // item payload and last counter write
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         s2_idx_ff   <= pht_req.pht_idx;
         s2_taken_ff <= pht_req.taken;
      end
      if (ctl.advance) begin
         fwd_idx_ff <= s2_idx_ff;
         fwd_cnt_ff <= cnt_next;
      end
   end

   // pattern table: read on load, write back as the item moves on
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pht_rd_ff <= pht_mem_ff[pht_req.pht_idx];
      end
      if (clr.active) begin
         pht_mem_ff[clr.index[PHT_INDEX_BITS-1:0]] <= CNT_WEAK_T;
      end else if (ctl.advance) begin
         pht_mem_ff[s2_idx_ff] <= cnt_next;
      end
   end

endmodule

@@ rtl/two_level_branch_predictor_top.sv @@
// channel   direction  fields                            accepted when
// req_bus   in         branch_address[31:0], taken       valid && ready
// rsp_bus   out        predicted_taken                   valid && ready
//
// one item per cycle unless rsp_bus stalls; each prediction is offered once its item
// has passed history read, pattern read and output register; forwarding the last write
// into the next read of the same entry closes the read-modify-write loop on each table
// after reset both tables are swept, one entry a cycle over the 4096 entries of the deeper
// table, and req_bus.ready stays low until the sweep is done
// a stalled rsp_bus holds the output register; the two stages ahead keep filling
module two_level_branch_predictor_top (
   input logic       clock,
   input logic       reset,
   tbp_req_if.sink   req_bus,
   tbp_rsp_if.source rsp_bus
);
   import tbp_pkg::*;

   clear_type     clr;
   logic          clr_active_ff;
   clear_idx_type clr_index_ff;
   stage_ctl_type s1_ctl;
   stage_ctl_type s2_ctl;
   pht_req_type   pht_req;
   pred_type      pred;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_pred_ff;
   logic          accept;
   logic          s1_adv;
   logic          s2_adv;

   // reset sweep over both tables
   assign clr.active = clr_active_ff;
   assign clr.index  = clr_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_index_ff  <= '0;
      end else if (clr_active_ff) begin
         clr_index_ff <= clr_index_ff + 1'b1;
         if (clr_index_ff == '1) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // pipeline flow, each stage moves when the one ahead has room
   always_comb begin
      s2_adv         = pred.valid && (!rsp_valid_ff || rsp_bus.ready);
      s1_adv         = pht_req.valid && (!pred.valid || s2_adv);
      req_bus.ready  = !clr_active_ff && (!pht_req.valid || s1_adv);
      accept         = req_bus.valid && req_bus.ready;
      s1_ctl.load    = accept;
      s1_ctl.advance = s1_adv;
      s2_ctl.load    = s1_adv;
      s2_ctl.advance = s2_adv;
   end

   tbp_hist_stage u_hist (
      .clock    (clock),
      .reset    (reset),
      .clr      (clr),
      .ctl      (s1_ctl),
      .in_addr  (req_bus.branch_address),
      .in_taken (req_bus.taken),
      .pht_req  (pht_req)
   );

   tbp_pattern_stage u_pattern (
      .clock   (clock),
      .reset   (reset),
      .clr     (clr),
      .ctl     (s2_ctl),
      .pht_req (pht_req),
      .pred    (pred)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_pred_ff <= pred.predicted;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.predicted_taken = rsp_pred_ff;

   // no item enters while the tables are being swept
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req_bus.ready)
      else $error("item accepted during table sweep");

   // sweep ends only after the last entry was written
   a_sweep_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_active_ff) |-> ($past(clr_index_ff) == '1))
      else $error("table sweep ended early");

   // an accepted item occupies the history stage next cycle
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> pht_req.valid)
      else $error("accepted item lost in history stage");

   // a prediction leaving the pattern stage is offered next cycle
   a_pred_reaches_out: assert property (@(posedge clock) disable iff (reset)
      s2_adv |=> rsp_bus.valid)
      else $error("prediction lost before output");

endmodule

@@ tb/sv/two_level_branch_predictor_top_tb.sv @@
module two_level_branch_predictor_top_tb;
   import tbp_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int PHASE_ITEMS   = 480;
   localparam int HOLD_CYCLES   = 80;
   localparam int POOL_SIZE     = 16;

   // per-address histories and shared counters, mirrored outside the block
   class branch_scoreboard;
      hist_type    history [1 << BHT_INDEX_BITS];
      counter_type counters [1 << PHT_INDEX_BITS];
      logic        predictions [$];
      int          errors;
      int          checked;
      int          taken_hits;

      function new();
         foreach (history[i]) history[i] = '0;
         foreach (counters[i]) counters[i] = CNT_WEAK_T;
         errors     = 0;
         checked    = 0;
         taken_hits = 0;
      endfunction

      // accepted branch: predict from the current counter, then train
      function void note_branch(addr_type addr, logic taken);
         bht_idx_type                      hist_sel;
         hist_type                         hist;
         logic [ADDR_BITS+HISTORY_BITS-1:0] joined;
         pht_idx_type                      cnt_sel;
         counter_type                      cnt;
         hist_sel = addr[BHT_INDEX_BITS+1:2];
         hist     = history[hist_sel];
         joined   = {addr >> 2, hist};
         cnt_sel  = joined[PHT_INDEX_BITS-1:0];
         cnt      = counters[cnt_sel];
         predictions.push_back(cnt >= CNT_WEAK_T);
         if (taken) begin
            if (cnt != CNT_STRONG_T) cnt = cnt + 2'd1;
         end else begin
            if (cnt != CNT_STRONG_NT) cnt = cnt - 2'd1;
         end
         counters[cnt_sel] = cnt;
         history[hist_sel] = hist_type'((hist << 1) | hist_type'(taken));
      endfunction

      // accepted prediction against the oldest one waiting
      function void check_prediction(logic actual);
         logic wanted;
         if (predictions.size() == 0) begin
            $display("%0t: unexpected prediction, expected none, actual %b", $time, actual);
            errors++;
         end else begin
            wanted = predictions.pop_front();
            checked++;
            if (actual === 1'b1) taken_hits++;
            if (actual !== wanted) begin
               $display("%0t: predicted_taken mismatch, expected %b, actual %b",
                        $time, wanted, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   hold_requests;
   int   hold_served;
   int   hold_left;
   int   sent;

   addr_type address_pool [POOL_SIZE];

   branch_scoreboard sb;

   tbp_req_if req_bus ();
   tbp_rsp_if rsp_bus ();

   two_level_branch_predictor_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // clock
   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("two_level_branch_predictor_top verification failed");
         $finish;
      end
   end

   // result side: check accepted items, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         sb.check_prediction(rsp_bus.predicted_taken);
      end
      if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served   <= hold_served + 1;
         hold_left     <= HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // offer one branch, wait for it to be taken
   task automatic send_branch(input addr_type addr, input logic taken);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.branch_address <= addr_type'($urandom);
         req_bus.taken <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.branch_address <= addr;
      req_bus.taken          <= taken;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_branch(addr, taken);
      sent++;
   endtask

   // pool entry with random bits outside the index ranges
   function automatic addr_type pool_address(int sel);
      addr_type a;
      a = address_pool[sel];
      if ($urandom_range(1)) a[1:0] = 2'($urandom);
      if ($urandom_range(3) == 0) a[31:12] = 20'($urandom);
      return a;
   endfunction

   // one burst: loop branch, periodic pattern, or noise
   task automatic send_burst();
      addr_type a;
      int       kind;
      int       trips;
      int       reps;
      logic [3:0] pattern;
      int       period;
      kind = $urandom_range(9);
      if (kind < 4) begin
         // loop branch: taken until the exit
         a     = pool_address($urandom_range(POOL_SIZE - 1));
         trips = $urandom_range(8, 1);
         reps  = $urandom_range(4, 1);
         for (int r = 0; r < reps; r++) begin
            for (int k = 0; k < trips; k++) send_branch(a, k != trips - 1);
         end
      end else if (kind < 7) begin
         // short repeating outcome pattern
         a       = pool_address($urandom_range(POOL_SIZE - 1));
         pattern = 4'($urandom);
         period  = $urandom_range(4, 1);
         reps    = $urandom_range(6, 2);
         for (int r = 0; r < reps * period; r++) send_branch(a, pattern[r % period]);
      end else if (kind < 9) begin
         // two branches interleaved, hitting nearby entries
         for (int k = 0; k < $urandom_range(12, 4); k++) begin
            send_branch(pool_address($urandom_range(1)), 1'($urandom_range(1)));
         end
      end else begin
         // noise over the whole address space
         for (int k = 0; k < $urandom_range(6, 1); k++) begin
            send_branch(addr_type'($urandom), 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
      int target;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target = sent + items;
      while (sent < target) send_burst();
   endtask

   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      cycle_count            = 0;
      send_idle_pct          = 0;
      rsp_stall_pct          = 0;
      hold_requests          = 0;
      hold_served            = 0;
      hold_left              = 0;
      sent                   = 0;
      req_bus.valid          = 1'b0;
      req_bus.branch_address = '0;
      req_bus.taken          = 1'b0;
      rsp_bus.ready          = 1'b0;
      sb = new();
      foreach (address_pool[i]) address_pool[i] = addr_type'($urandom);
      // neighbors: one on the adjacent history entry, one sharing history and pattern entries
      address_pool[1] = address_pool[0] ^ 32'h0000_0004;
      address_pool[2] = address_pool[0] ^ 32'hFFFF_FC00;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: first lookups see weakly taken counters and empty history
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'h0000_0000, 1'b1);
      // aliases of address zero: ignored high and low bits
      send_branch(32'hFFFF_FC00, 1'b0);
      send_branch(32'h0000_0003, 1'b0);
      // all-ones address driven down to strongly not taken
      for (int k = 0; k < 8; k++) send_branch(32'hFFFF_FFFF, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b1);
      // same branch hammered taken until its history and counter saturate
      for (int k = 0; k < 8; k++) send_branch(32'h0000_0010, 1'b1);
      // alternating outcomes walk the history
      send_branch(32'h0000_0014, 1'b1);
      send_branch(32'h0000_0014, 1'b0);
      send_branch(32'h0000_0014, 1'b1);

      // random traffic over the idling phases
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(56, 0, PHASE_ITEMS);
      run_phase(0, 56, PHASE_ITEMS);
      run_phase(7, 7, PHASE_ITEMS);

      // long receiver hold-off while the sender keeps offering
      hold_requests = hold_requests + 1;
      run_phase(0, 0, 120);

      // last item was taken at this edge, drop valid right away
      req_bus.valid <= 1'b0;
      while (sb.predictions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d branches across four idling phases and one long output stall",
               sent);
      $display("checked %0d predictions, %0d of them taken", sb.checked, sb.taken_hits);
      if (sb.errors == 0) begin
         $display("two_level_branch_predictor_top verification clean");
      end else begin
         $display("two_level_branch_predictor_top verification failed");
      end
      $finish;
   end

endmodule
